/* rtl/lp2c_pkg.sv */
// shared types, constants and the cordic arctangent table
// for the laser polar-to-cartesian converter; no dependencies
package lp2c_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int INDEX_BITS    = 12;

  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int CELL_IDX_W    = $clog2(ATAN_ENTRIES);

  localparam int RANGE_W  = 24;
  localparam int ANGLE_W  = 16;
  localparam int COORD_W  = 25;
  localparam int CORDIC_W = 32;
  localparam int PROD_W   = RANGE_W + 1 + CORDIC_W;

  // front register, cordic cells, multiply, round
  localparam int LATENCY = NUM_CELLS + 3;

  localparam logic signed [CORDIC_W-1:0] GAIN_Q30  = 32'sd652032874;
  localparam logic [RANGE_W-1:0]         COORD_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    REG_MIN_RANGE   = 2'd0,
    REG_MAX_RANGE   = 2'd1,
    REG_FIRST_ANGLE = 2'd2,
    REG_ANGLE_STEP  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [RANGE_W-1:0] min_range;
    logic [RANGE_W-1:0] max_range;
    logic [ANGLE_W-1:0] first_angle;
    logic [ANGLE_W-1:0] angle_step;
  } cfg_t;

  // one beam in flight through the rotation chain
  typedef struct packed {
    logic                       valid;
    logic [INDEX_BITS-1:0]      idx;
    logic [RANGE_W-1:0]         r;
    logic                       flip;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cell_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [CELL_IDX_W-1:0] i);
    logic signed [CORDIC_W-1:0] v;
    unique case (i)
      5'd0:    v = 32'sh20000000;
      5'd1:    v = 32'sh12E4051E;
      5'd2:    v = 32'sh09FB385B;
      5'd3:    v = 32'sh051111D4;
      5'd4:    v = 32'sh028B0D43;
      5'd5:    v = 32'sh0145D7E1;
      5'd6:    v = 32'sh00A2F61E;
      5'd7:    v = 32'sh00517C55;
      5'd8:    v = 32'sh0028BE53;
      5'd9:    v = 32'sh00145F2F;
      5'd10:   v = 32'sh000A2F98;
      5'd11:   v = 32'sh000517CC;
      5'd12:   v = 32'sh00028BE6;
      5'd13:   v = 32'sh000145F3;
      5'd14:   v = 32'sh0000A2FA;
      5'd15:   v = 32'sh0000517D;
      5'd16:   v = 32'sh000028BE;
      5'd17:   v = 32'sh0000145F;
      5'd18:   v = 32'sh00000A30;
      5'd19:   v = 32'sh00000518;
      5'd20:   v = 32'sh0000028C;
      5'd21:   v = 32'sh00000146;
      5'd22:   v = 32'sh000000A3;
      5'd23:   v = 32'sh00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/laser_polar_to_cartesian.sv */
// top level of the laser polar-to-cartesian converter
// depends on lp2c_pkg, lp2c_front, lp2c_cell, lp2c_scale
//
// converts one laser beam per clock from (beam_index, range) to a point
// (x_pos, y_pos) in Q16.8 metres. a beam is taken at every clock edge with
// start high and busy low; busy is high only while rst is asserted, so after
// reset the block takes a new item on every cycle. a beam whose range is not
// strictly between min_range and max_range is dropped and produces no
// result. a kept beam comes out as a one-cycle done strobe with
// beam_index_res, x_pos and y_pos; on its way it passes one register for
// the gate and angle computation, one per cordic cell in the rotation chain,
// one for the range multiply and one for rounding. results arrive in input
// order and the receiver has no way to hold them off. the angle is
// first_angle + beam_index * angle_step, wrapping at a full turn of 65536.
// registers are written through cfg_wr/cfg_index/cfg_data; write them only
// while no beam is in flight
module laser_polar_to_cartesian (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [lp2c_pkg::INDEX_BITS-1:0]       beam_index,
  input  logic [lp2c_pkg::RANGE_W-1:0]          range,
  input  logic                                  cfg_wr,
  input  logic [1:0]                            cfg_index,
  input  logic [lp2c_pkg::RANGE_W-1:0]          cfg_data,
  output logic                                  done,
  output logic [lp2c_pkg::INDEX_BITS-1:0]       beam_index_res,
  output logic signed [lp2c_pkg::COORD_W-1:0]   x_pos,
  output logic signed [lp2c_pkg::COORD_W-1:0]   y_pos
);

  lp2c_pkg::cfg_t  cfg;
  logic            accept;
  // chain[0] is the seeded beam, chain[NUM_CELLS] the fully rotated one
  lp2c_pkg::cell_t chain [0:lp2c_pkg::NUM_CELLS];

  assign busy   = rst;
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_range   <= 24'd0;
      cfg.max_range   <= 24'd12800;
      cfg.first_angle <= 16'hC000;
      cfg.angle_step  <= 16'd364;
    end else if (cfg_wr) begin
      unique case (lp2c_pkg::reg_idx_t'(cfg_index))
        lp2c_pkg::REG_MIN_RANGE:   cfg.min_range   <= cfg_data;
        lp2c_pkg::REG_MAX_RANGE:   cfg.max_range   <= cfg_data;
        lp2c_pkg::REG_FIRST_ANGLE: cfg.first_angle <= cfg_data[lp2c_pkg::ANGLE_W-1:0];
        lp2c_pkg::REG_ANGLE_STEP:  cfg.angle_step  <= cfg_data[lp2c_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // gate, angle and quadrant fold
  lp2c_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .beam_index (beam_index),
    .range      (range),
    .cfg        (cfg),
    .seed       (chain[0])
  );

  // rotation chain, one micro-rotation per cell
  for (genvar i = 0; i < lp2c_pkg::NUM_CELLS; i++) begin : g_cell
    lp2c_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_idx (lp2c_pkg::CELL_IDX_W'(i)),
      .din       (chain[i]),
      .dout      (chain[i+1])
    );
  end

  // range multiply, rounding and output register
  lp2c_scale u_scale (
    .clk            (clk),
    .rst            (rst),
    .din            (chain[lp2c_pkg::NUM_CELLS]),
    .done           (done),
    .beam_index_res (beam_index_res),
    .x_pos          (x_pos),
    .y_pos          (y_pos)
  );

  // a result always traces back to an item taken a fixed latency earlier
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, lp2c_pkg::LATENCY))
    else $error("result without matching item");

  // beams outside the gate never produce a point
  a_gate_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && !((range > cfg.min_range) && (range < cfg.max_range)))
      |-> ##(lp2c_pkg::LATENCY) !done)
    else $error("gated beam produced a point");

  // saturation keeps coordinates symmetric
  a_coord_sym: assert property (@(posedge clk) disable iff (rst)
    done |-> (x_pos != {1'b1, {(lp2c_pkg::COORD_W-1){1'b0}}})
          && (y_pos != {1'b1, {(lp2c_pkg::COORD_W-1){1'b0}}}))
    else $error("coordinate beyond saturation limit");

  // the beam index rides along unchanged
  a_index_kept: assert property (@(posedge clk) disable iff (rst)
    done |-> beam_index_res == $past(beam_index, lp2c_pkg::LATENCY))
    else $error("beam index corrupted");

endmodule

/* rtl/lp2c_front.sv */
// entry stage: range gate, beam angle, quadrant fold, cordic seed
// depends on lp2c_pkg
module lp2c_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [lp2c_pkg::INDEX_BITS-1:0]     beam_index,
  input  logic [lp2c_pkg::RANGE_W-1:0]        range,
  input  lp2c_pkg::cfg_t                      cfg,
  output lp2c_pkg::cell_t                     seed
);

  logic                                  pass;
  logic [lp2c_pkg::ANGLE_W-1:0]          angle;
  logic signed [lp2c_pkg::ANGLE_W-1:0]   s;
  logic signed [lp2c_pkg::ANGLE_W-1:0]   s_fold;
  logic                                  flip;
  lp2c_pkg::cell_t                       seed_next;

  assign pass  = (range > cfg.min_range) && (range < cfg.max_range);
  assign angle = cfg.first_angle
               + lp2c_pkg::ANGLE_W'(beam_index * cfg.angle_step);
  assign s     = $signed(angle);

  // fold into [-quarter, +quarter], sign flip restored after rotation
  always_comb begin
    priority if (s > 16'sd16384) begin
      s_fold = s - 16'sd32767 - 16'sd1;
      flip   = 1'b1;
    end else if (s < -16'sd16384) begin
      s_fold = s + 16'sd32767 + 16'sd1;
      flip   = 1'b1;
    end else begin
      s_fold = s;
      flip   = 1'b0;
    end
  end

  always_comb begin
    seed_next.valid = accept && pass;
    seed_next.idx   = beam_index;
    seed_next.r     = range;
    seed_next.flip  = flip;
    seed_next.x     = lp2c_pkg::GAIN_Q30;
    seed_next.y     = '0;
    seed_next.z     = {s_fold, 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed.valid <= 1'b0;
    end else begin
      seed.valid <= seed_next.valid;
    end
    seed.idx  <= seed_next.idx;
    seed.r    <= seed_next.r;
    seed.flip <= seed_next.flip;
    seed.x    <= seed_next.x;
    seed.y    <= seed_next.y;
    seed.z    <= seed_next.z;
  end

endmodule

/* rtl/lp2c_cell.sv */
// one cordic rotation step with its pipeline register
// depends on lp2c_pkg
module lp2c_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [lp2c_pkg::CELL_IDX_W-1:0]    stage_idx,
  input  lp2c_pkg::cell_t                    din,
  output lp2c_pkg::cell_t                    dout
);

  logic signed [lp2c_pkg::CORDIC_W-1:0] dx;
  logic signed [lp2c_pkg::CORDIC_W-1:0] dy;
  logic signed [lp2c_pkg::CORDIC_W-1:0] atan_i;
  lp2c_pkg::cell_t                      dout_next;

  assign dx     = din.y >>> stage_idx;
  assign dy     = din.x >>> stage_idx;
  assign atan_i = lp2c_pkg::atan_turn(stage_idx);

  always_comb begin
    dout_next = din;
    if (!din.z[lp2c_pkg::CORDIC_W-1]) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.z = din.z - atan_i;
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.z = din.z + atan_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= dout_next.valid;
    end
    dout.idx  <= dout_next.idx;
    dout.r    <= dout_next.r;
    dout.flip <= dout_next.flip;
    dout.x    <= dout_next.x;
    dout.y    <= dout_next.y;
    dout.z    <= dout_next.z;
  end

endmodule

/* rtl/lp2c_scale.sv */
// range times cos/sin, rounding half away from zero and saturation
// depends on lp2c_pkg
module lp2c_scale (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lp2c_pkg::cell_t                       din,
  output logic                                  done,
  output logic [lp2c_pkg::INDEX_BITS-1:0]       beam_index_res,
  output logic signed [lp2c_pkg::COORD_W-1:0]   x_pos,
  output logic signed [lp2c_pkg::COORD_W-1:0]   y_pos
);

  localparam int MAG_W = lp2c_pkg::PROD_W - 1;
  localparam int RND_W = MAG_W - 29;

  logic                                    prod_valid;
  logic [lp2c_pkg::INDEX_BITS-1:0]         prod_idx;
  logic                                    prod_flip;
  logic signed [lp2c_pkg::PROD_W-1:0]      prod_x;
  logic signed [lp2c_pkg::PROD_W-1:0]      prod_y;
  logic signed [lp2c_pkg::PROD_W-1:0]      prod_x_next;
  logic signed [lp2c_pkg::PROD_W-1:0]      prod_y_next;

  assign prod_x_next = $signed({1'b0, din.r}) * din.x;
  assign prod_y_next = $signed({1'b0, din.r}) * din.y;

  function automatic logic signed [lp2c_pkg::COORD_W-1:0] round_sat(
    input logic signed [lp2c_pkg::PROD_W-1:0] p,
    input logic                               flip
  );
    logic                        neg;
    logic [MAG_W-1:0]            mag;
    logic [RND_W-1:0]            m;
    logic [lp2c_pkg::RANGE_W-1:0] m_sat;
    logic [lp2c_pkg::COORD_W-1:0] u;
    neg   = p[lp2c_pkg::PROD_W-1] ^ flip;
    mag   = p[lp2c_pkg::PROD_W-1] ? MAG_W'(-p) : p[MAG_W-1:0];
    m     = RND_W'((mag + (MAG_W'(1) << 29)) >> 30);
    m_sat = (m > RND_W'(lp2c_pkg::COORD_MAX)) ? lp2c_pkg::COORD_MAX
                                              : m[lp2c_pkg::RANGE_W-1:0];
    u     = {1'b0, m_sat};
    return neg ? $signed(-u) : $signed(u);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= din.valid;
      done       <= prod_valid;
    end
    prod_idx       <= din.idx;
    prod_flip      <= din.flip;
    prod_x         <= prod_x_next;
    prod_y         <= prod_y_next;
    beam_index_res <= prod_idx;
    x_pos          <= round_sat(prod_x, prod_flip);
    y_pos          <= round_sat(prod_y, prod_flip);
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for laser_polar_to_cartesian: range gate, beam angle,
// cordic rotation and rounding are predicted per item and compared per point
// depends on lp2c_pkg and the laser_polar_to_cartesian rtl
module tb_top;

  // one converted point as the block should emit it
  typedef struct packed {
    logic [lp2c_pkg::INDEX_BITS-1:0]      idx;
    logic signed [lp2c_pkg::COORD_W-1:0]  x;
    logic signed [lp2c_pkg::COORD_W-1:0]  y;
  } point_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 start = 1'b0;
  logic [lp2c_pkg::INDEX_BITS-1:0]      beam_index = '0;
  logic [lp2c_pkg::RANGE_W-1:0]         range = '0;
  logic                                 cfg_wr = 1'b0;
  logic [1:0]                           cfg_index = '0;
  logic [lp2c_pkg::RANGE_W-1:0]         cfg_data = '0;
  logic                                 busy;
  logic                                 done;
  logic [lp2c_pkg::INDEX_BITS-1:0]      beam_index_res;
  logic signed [lp2c_pkg::COORD_W-1:0]  x_pos;
  logic signed [lp2c_pkg::COORD_W-1:0]  y_pos;

  // bench copy of the register file, reset values
  logic [lp2c_pkg::RANGE_W-1:0] gate_lo = '0;
  logic [lp2c_pkg::RANGE_W-1:0] gate_hi = 24'd12800;
  logic [lp2c_pkg::ANGLE_W-1:0] angle_base = 16'hC000;
  logic [lp2c_pkg::ANGLE_W-1:0] angle_step_q = 16'd364;

  // atan(2^-i) in 2^32 per turn
  longint atan_tbl [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  point_t pending_points [$];
  int     points_expected = 0;
  int     errors = 0;

  laser_polar_to_cartesian dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .beam_index     (beam_index),
    .range          (range),
    .cfg_wr         (cfg_wr),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .beam_index_res (beam_index_res),
    .x_pos          (x_pos),
    .y_pos          (y_pos)
  );

  always #1 clk = ~clk;

  // generous ceiling, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // q.38 product to q16.8, half away from zero, magnitude clamped
  function automatic logic signed [lp2c_pkg::COORD_W-1:0] round_coord(input longint p);
    longint mag;
    mag = (p < 0) ? -p : p;
    mag = (mag + (longint'(1) << 29)) >>> 30;
    if (mag > 64'sd16777215) mag = 64'sd16777215;
    if (p < 0) mag = -mag;
    return mag[lp2c_pkg::COORD_W-1:0];
  endfunction

  // gate the beam and, if kept, rotate the range onto x/y
  function automatic bit convert_beam(input logic [lp2c_pkg::INDEX_BITS-1:0] idx,
                                      input logic [lp2c_pkg::RANGE_W-1:0] r,
                                      output point_t pt);
    logic [31:0] sum;
    longint      s, x, y, z, dx, dy;
    bit          flip;
    pt = '0;
    flip = 1'b0;
    if (!(r > gate_lo && r < gate_hi)) return 1'b0;
    sum = {16'b0, angle_base} + idx * angle_step_q;
    s = longint'($signed(sum[lp2c_pkg::ANGLE_W-1:0]));
    // fold the outer half turn into [-90, 90] degrees and remember the sign swap
    if (s > 16384) begin
      s = s - 32768;
      flip = 1'b1;
    end else if (s < -16384) begin
      s = s + 32768;
      flip = 1'b1;
    end
    z = s * 65536;
    x = longint'(lp2c_pkg::GAIN_Q30);
    y = 0;
    for (int i = 0; i < lp2c_pkg::CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tbl[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tbl[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    pt.idx = idx;
    pt.x = round_coord(longint'(r) * x);
    pt.y = round_coord(longint'(r) * y);
    return 1'b1;
  endfunction

  // mostly back to back, sometimes short pauses, rarely long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // present one beam, wait for the accepting edge, log the expected point
  task automatic send_beam(input logic [lp2c_pkg::INDEX_BITS-1:0] idx,
                           input logic [lp2c_pkg::RANGE_W-1:0] r, input int gap);
    point_t pt;
    start <= 1'b1;
    beam_index <= idx;
    range <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (convert_beam(idx, r, pt)) begin
      pending_points = {pending_points, pt};
      points_expected++;
    end
    // with no gap start stays high so the next item goes in on the next edge
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all expected points, then let dropped beams clear the pipe too
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (lp2c_pkg::LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input lp2c_pkg::reg_idx_t which,
                           input logic [lp2c_pkg::RANGE_W-1:0] value);
    cfg_wr <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    case (which)
      lp2c_pkg::REG_MIN_RANGE:   gate_lo = value;
      lp2c_pkg::REG_MAX_RANGE:   gate_hi = value;
      lp2c_pkg::REG_FIRST_ANGLE: angle_base = value[lp2c_pkg::ANGLE_W-1:0];
      lp2c_pkg::REG_ANGLE_STEP:  angle_step_q = value[lp2c_pkg::ANGLE_W-1:0];
      default: ;
    endcase
  endtask

  // all four registers back to back; angle writes carry junk in the unused top byte
  task automatic set_config(input logic [lp2c_pkg::RANGE_W-1:0] lo,
                            input logic [lp2c_pkg::RANGE_W-1:0] hi,
                            input logic [lp2c_pkg::ANGLE_W-1:0] base,
                            input logic [lp2c_pkg::ANGLE_W-1:0] step);
    write_reg(lp2c_pkg::REG_MIN_RANGE, lo);
    write_reg(lp2c_pkg::REG_MAX_RANGE, hi);
    write_reg(lp2c_pkg::REG_FIRST_ANGLE, {8'($urandom), base});
    write_reg(lp2c_pkg::REG_ANGLE_STEP, {8'($urandom), step});
    cfg_wr <= 1'b0;
  endtask

  // reset register values: gate 0..50 m, scan starting at -90 degrees
  task automatic test_defaults();
    send_beam(12'd0, 24'd0, 0);
    send_beam(12'd0, 24'd1, 0);
    send_beam(12'd4095, 24'd12799, pick_gap());
    send_beam(12'd495, 24'd12800, 0);
    send_beam(12'd360, 24'd2560, pick_gap());
    wait_idle();
  endtask

  // equality at either gate drops the beam; a closed or inverted gate drops all
  task automatic test_range_gate();
    set_config(24'd100, 24'd200, 16'h0000, 16'd91);
    send_beam(12'd1, 24'd100, 0);
    send_beam(12'd2, 24'd101, 0);
    send_beam(12'd3, 24'd199, 0);
    send_beam(12'd4, 24'd200, pick_gap());
    wait_idle();
    set_config(24'd500, 24'd500, 16'h0000, 16'd91);
    send_beam(12'd5, 24'd500, 0);
    send_beam(12'd6, 24'd499, 0);
    wait_idle();
    set_config(24'd600, 24'd500, 16'h0000, 16'd91);
    send_beam(12'd7, 24'd550, 0);
    wait_idle();
    set_config(24'd0, 24'hFFFFFF, 16'h0000, 16'd91);
    send_beam(12'd8, 24'hFFFFFE, 0);
    send_beam(12'd9, 24'hFFFFFF, 0);
    wait_idle();
  endtask

  // step 0 pins every beam to first_angle; near full-scale range hits the clamp
  task automatic test_quadrant_fold();
    logic [lp2c_pkg::ANGLE_W-1:0] angles [8] = '{16'h0000, 16'h4000, 16'h4001, 16'hC000,
                                                 16'hBFFF, 16'h8000, 16'h7FFF, 16'h2000};
    foreach (angles[k]) begin
      set_config(24'd0, 24'hFFFFFF, angles[k], 16'd0);
      send_beam(12'($urandom), 24'hFFFFFE, 0);
      wait_idle();
    end
  endtask

  // angle sum wraps past a full turn
  task automatic test_angle_wrap();
    set_config(24'd0, 24'hFFFFFF, 16'h7FFF, 16'hFFFF);
    send_beam(12'd4095, 24'd70000, 0);
    send_beam(12'd1, 24'd70000, 0);
    wait_idle();
    set_config(24'd0, 24'hFFFFFF, 16'hFFFF, 16'h8000);
    send_beam(12'd4095, 24'h123456, 0);
    send_beam(12'd2048, 24'h123456, 0);
    wait_idle();
  endtask

  // several register settings, mostly in-gate ranges with some gate hits and junk
  task automatic test_random_scans();
    logic [lp2c_pkg::RANGE_W-1:0]    lo, hi, r, tmp;
    logic [lp2c_pkg::INDEX_BITS-1:0] idx;
    int                              quota, first, items, p;
    bit                              burst;
    for (int phase = 0; phase < 7; phase++) begin
      quota = 220;
      burst = (phase == 1);
      case (phase)
        0: set_config(24'd0, 24'hFFFFFF, 16'h8000, 16'hFFFF);
        1: set_config(24'd0, 24'd12800, 16'hC000, 16'd364);
        2: begin
          lo = 24'($urandom_range(0, 24'h7FFFFF));
          hi = lo + 24'($urandom_range(2, 24'hFFFFFF - lo));
          set_config(lo, hi, 16'($urandom), 16'($urandom));
        end
        3: begin
          // closed gate: nothing may come out
          lo = 24'($urandom_range(1000, 24'hFFFFFF));
          set_config(lo, lo - 24'($urandom_range(0, 1000)), 16'($urandom), 16'($urandom));
          quota = 0;
        end
        4: set_config(24'd1, 24'hFFFFFE, 16'h7FFF, 16'd0);
        5: set_config(24'($urandom_range(0, 255)), 24'($urandom_range(4096, 24'hFFFFFF)),
                      16'($urandom), 16'($urandom_range(0, 16)));
        default: begin
          lo = 24'($urandom);
          hi = 24'($urandom);
          if (lo > hi) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
          end
          if (hi - lo < 2) hi = lo + 24'd2;
          set_config(lo, hi, 16'($urandom), 16'($urandom));
        end
      endcase
      first = points_expected;
      items = 0;
      while ((quota == 0) ? (items < 40)
                          : (points_expected - first < quota && items < 1000)) begin
        p = $urandom_range(0, 9);
        if (p <= 6 && gate_hi > gate_lo + 1)
          r = 24'($urandom_range(gate_lo + 1, gate_hi - 1));
        else if (p == 7)
          r = 24'($urandom);
        else if (p == 8)
          r = $urandom_range(0, 1) ? gate_lo : gate_hi;
        else
          r = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
        p = $urandom_range(0, 19);
        idx = (p == 0) ? 12'd0 : (p == 1) ? 12'hFFF : 12'($urandom);
        send_beam(idx, r, burst ? 0 : pick_gap());
        items++;
      end
      wait_idle();
    end
  endtask

  // results cannot be held off, so every done strobe is taken at the edge ending it
  always @(posedge clk) begin
    point_t want;
    if (!rst && done) begin
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point expected none got idx=%0d x=%0d y=%0d", $time,
                 beam_index_res, x_pos, y_pos);
      end else begin
        want = pending_points.pop_front();
        if (beam_index_res !== want.idx || x_pos !== want.x || y_pos !== want.y) begin
          errors++;
          $display("%0t: point mismatch expected idx=%0d x=%0d y=%0d got idx=%0d x=%0d y=%0d",
                   $time, want.idx, want.x, want.y, beam_index_res, x_pos, y_pos);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_range_gate();
    test_quadrant_fold();
    test_angle_wrap();
    test_random_scans();
    wait_idle();
    if (pending_points.size() != 0) errors++;
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
